[design/rdd_pkg.sv]
// Shared constants and register codes for the radix digit decomposer.
package rdd_pkg;

  localparam int MAX_DIGITS_DEF  = 16;
  localparam int INDEX_WIDTH_DEF = 32;
  localparam int DIGIT_WIDTH_DEF = 8;

  localparam int RADIX_WIDTH     = 9;
  localparam int COUNT_WIDTH     = 5;
  localparam int CFG_INDEX_WIDTH = 4;
  localparam int CFG_DATA_WIDTH  = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = RADIX_WIDTH'(2);
  localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = COUNT_WIDTH'(16);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_RADIX       = CFG_INDEX_WIDTH'(0),
    REG_DIGIT_COUNT = CFG_INDEX_WIDTH'(1)
  } cfg_reg_t;

endpackage

[design/rdd_place_table.sv]
// Configuration registers and place value table, rebuilt after each register write.
module rdd_place_table #(
  parameter int MAX_DIGITS  = 16,
  parameter int INDEX_WIDTH = 32,
  parameter int DIGIT_WIDTH = 8,
  localparam int RW = DIGIT_WIDTH + 1,
  localparam int CW = $clog2(MAX_DIGITS + 1),
  localparam int PW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rdd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [rdd_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
  output logic [RW-1:0]                       eff_radix,
  output logic [CW-1:0]                       eff_count,
  output logic [INDEX_WIDTH-1:0]              total,
  output logic                                total_sat,
  input  logic [PW-1:0]                       rd_addr,
  output logic [INDEX_WIDTH-1:0]              rd_data
);
  import rdd_pkg::*;

  localparam int PROD_W = INDEX_WIDTH + RW;

  typedef enum logic [1:0] {T_IDLE, T_INIT, T_FILL} tstate_t;

  tstate_t                 state_r;
  logic [RADIX_WIDTH-1:0]  radix_r;
  logic [COUNT_WIDTH-1:0]  count_r;
  logic [PW-1:0]           k_r;
  logic [INDEX_WIDTH-1:0]  acc_r;
  logic                    sat_r;
  logic [INDEX_WIDTH-1:0]  total_r;
  logic                    total_sat_r;
  logic [INDEX_WIDTH-1:0]  pv_r [MAX_DIGITS];

  logic [PROD_W-1:0]       prod;
  logic                    over;
  logic [INDEX_WIDTH-1:0]  acc_nxt;

  always_comb begin
    if (radix_r < RADIX_WIDTH'(2)) begin
      eff_radix = RW'(2);
    end else if (32'(radix_r) > (32'd1 << DIGIT_WIDTH)) begin
      eff_radix = RW'(32'd1 << DIGIT_WIDTH);
    end else begin
      eff_radix = RW'(radix_r);
    end
  end

  always_comb begin
    if (count_r == '0) begin
      eff_count = CW'(1);
    end else if (32'(count_r) > 32'(MAX_DIGITS)) begin
      eff_count = CW'(MAX_DIGITS);
    end else begin
      eff_count = CW'(count_r);
    end
  end

  assign prod    = {{RW{1'b0}}, acc_r} * {{INDEX_WIDTH{1'b0}}, eff_radix};
  assign over    = sat_r || (prod[PROD_W-1:INDEX_WIDTH] != '0);
  assign acc_nxt = over ? '1 : prod[INDEX_WIDTH-1:0];

  assign cfg_ready = (state_r == T_IDLE);
  assign total     = total_r;
  assign total_sat = total_sat_r;
  assign rd_data   = pv_r[rd_addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_INIT;
      radix_r     <= RADIX_RESET;
      count_r     <= COUNT_RESET;
      total_sat_r <= 1'b0;
    end else begin
      case (state_r)
        T_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == REG_RADIX) begin
              radix_r <= cfg_wdata[RADIX_WIDTH-1:0];
              state_r <= T_INIT;
            end else if (cfg_index == REG_DIGIT_COUNT) begin
              count_r <= cfg_wdata[COUNT_WIDTH-1:0];
              state_r <= T_INIT;
            end
          end
        end
        T_INIT: begin
          acc_r   <= INDEX_WIDTH'(1);
          sat_r   <= 1'b0;
          k_r     <= PW'(eff_count - CW'(1));
          state_r <= T_FILL;
        end
        T_FILL: begin
          pv_r[k_r] <= acc_r;
          acc_r     <= acc_nxt;
          sat_r     <= over;
          if (k_r == '0) begin
            total_r     <= acc_nxt;
            total_sat_r <= over;
            state_r     <= T_IDLE;
          end else begin
            k_r <= k_r - PW'(1);
          end
        end
        default: begin
          state_r <= T_IDLE;
        end
      endcase
    end
  end

endmodule

[design/rdd_front.sv]
// Front end: take an index, flag it out of range and fold it below the total.
module rdd_front #(
  parameter int INDEX_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [INDEX_WIDTH-1:0] index_i,
  input  logic [INDEX_WIDTH-1:0] total_i,
  input  logic                   total_sat_i,
  output logic                   busy_o,
  output logic                   q_push,
  output logic [INDEX_WIDTH:0]   q_data,
  input  logic                   q_full
);
  import rdd_pkg::*;

  localparam int SW = $clog2(INDEX_WIDTH);

  typedef enum logic [1:0] {F_IDLE, F_REDUCE, F_PUSH} fstate_t;

  fstate_t                state_r;
  logic [INDEX_WIDTH-1:0] x_r;
  logic [INDEX_WIDTH-1:0] rem_r;
  logic                   oor_r;
  logic [SW-1:0]          cnt_r;

  logic [INDEX_WIDTH:0]   shifted;
  logic [INDEX_WIDTH:0]   diff;
  logic                   ge;
  logic [INDEX_WIDTH-1:0] rem_nxt;
  logic                   oor_nxt;

  assign shifted = {rem_r, x_r[INDEX_WIDTH-1]};
  assign diff    = shifted - {1'b0, total_i};
  assign ge      = shifted >= {1'b0, total_i};
  assign rem_nxt = ge ? diff[INDEX_WIDTH-1:0] : shifted[INDEX_WIDTH-1:0];
  assign oor_nxt = !total_sat_i && (index_i >= total_i);

  assign busy_o = (state_r != F_IDLE);
  assign q_push = (state_r == F_PUSH) && !q_full;
  assign q_data = {oor_r, rem_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            x_r   <= index_i;
            oor_r <= oor_nxt;
            cnt_r <= '0;
            if (oor_nxt) begin
              rem_r   <= '0;
              state_r <= F_REDUCE;
            end else begin
              rem_r   <= index_i;
              state_r <= F_PUSH;
            end
          end
        end
        F_REDUCE: begin
          rem_r <= rem_nxt;
          x_r   <= {x_r[INDEX_WIDTH-2:0], 1'b0};
          cnt_r <= cnt_r + SW'(1);
          if (cnt_r == SW'(INDEX_WIDTH - 1)) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

endmodule

[design/rdd_queue.sv]
// Short queue between the front end and the digit engine.
module rdd_queue #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  import rdd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [NW-1:0]    fill_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (fill_r == NW'(DEPTH));
  assign empty    = (fill_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + NW'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - NW'(1);
      end
    end
  end

endmodule

[design/rdd_back.sv]
// Digit engine: restoring division by each place value, one quotient bit a cycle.
module rdd_back #(
  parameter int MAX_DIGITS  = 16,
  parameter int INDEX_WIDTH = 32,
  parameter int DIGIT_WIDTH = 8,
  localparam int CW = $clog2(MAX_DIGITS + 1),
  localparam int PW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  logic [INDEX_WIDTH:0]   q_rdata,
  output logic                   q_pop,
  input  logic [CW-1:0]          eff_count,
  output logic [PW-1:0]          pv_addr,
  input  logic [INDEX_WIDTH-1:0] pv_data,
  output logic                   out_strobe,
  output logic [DIGIT_WIDTH-1:0] out_digit,
  output logic [PW-1:0]          out_position,
  output logic                   out_last,
  output logic                   out_oor
);
  import rdd_pkg::*;

  localparam int SW = (DIGIT_WIDTH > 1) ? $clog2(DIGIT_WIDTH) : 1;
  localparam int TW = INDEX_WIDTH + DIGIT_WIDTH;

  typedef enum logic {B_IDLE, B_DIV} bstate_t;

  bstate_t                state_r;
  logic [INDEX_WIDTH-1:0] rem_r;
  logic                   oor_r;
  logic [PW-1:0]          pos_r;
  logic [SW-1:0]          step_r;
  logic [DIGIT_WIDTH-1:0] q_r;
  logic                   out_strobe_r;
  logic [DIGIT_WIDTH-1:0] out_digit_r;
  logic [PW-1:0]          out_position_r;
  logic                   out_last_r;
  logic                   out_oor_r;

  logic [TW-1:0]          trial;
  logic                   ge;
  logic [INDEX_WIDTH-1:0] rem_nxt;
  logic [DIGIT_WIDTH-1:0] q_nxt;
  logic                   last_pos;
  logic                   zero_dig;

  assign trial    = {{DIGIT_WIDTH{1'b0}}, pv_data} << step_r;
  assign ge       = {{DIGIT_WIDTH{1'b0}}, rem_r} >= trial;
  assign rem_nxt  = (ge && !zero_dig) ? (rem_r - trial[INDEX_WIDTH-1:0]) : rem_r;
  assign last_pos = (CW'(CW'(pos_r) + CW'(1)) == eff_count);
  assign zero_dig = (pv_data == '1) && !last_pos;

  always_comb begin
    q_nxt         = q_r;
    q_nxt[step_r] = ge;
  end

  assign q_pop        = (state_r == B_IDLE) && !q_empty;
  assign pv_addr      = pos_r;
  assign out_strobe   = out_strobe_r;
  assign out_digit    = out_digit_r;
  assign out_position = out_position_r;
  assign out_last     = out_last_r;
  assign out_oor      = out_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            rem_r   <= q_rdata[INDEX_WIDTH-1:0];
            oor_r   <= q_rdata[INDEX_WIDTH];
            pos_r   <= '0;
            step_r  <= SW'(DIGIT_WIDTH - 1);
            q_r     <= '0;
            state_r <= B_DIV;
          end
        end
        B_DIV: begin
          rem_r <= rem_nxt;
          q_r   <= q_nxt;
          if (step_r == '0) begin
            out_strobe_r   <= 1'b1;
            out_digit_r    <= zero_dig ? '0 : q_nxt;
            out_position_r <= pos_r;
            out_last_r     <= last_pos;
            out_oor_r      <= oor_r;
            q_r            <= '0;
            step_r         <= SW'(DIGIT_WIDTH - 1);
            if (last_pos) begin
              state_r <= B_IDLE;
            end else begin
              pos_r <= pos_r + PW'(1);
            end
          end else begin
            step_r <= step_r - SW'(1);
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

[design/radix_digit_decomposer.sv]
// Radix digit decomposer: splits an unsigned index into base-radix digits, MSD first.
//
// Input beat: drive in_index_value with start high; it is taken on an edge where busy is
// low. Each index yields digit_count result beats, one cycle each on out_strobe, position 0
// (most significant) first; out_last marks the final digit, out_out_of_range marks every
// digit of an index at or above radix^digit_count (the higher part is dropped).
// Config: cfg_index 0 is radix, 1 is digit_count; write only when no index is in flight.
// A write to radix or digit_count rebuilds the place value table with one multiply a cycle,
// with cfg_ready and start-acceptance held off meanwhile.
// Flow: after each accepted index the front end holds busy while it pushes the index to the
// queue, waiting while the queue is full, and first folds the remainder when out of
// range, so it takes no new index before the last one is pushed. The digit engine finds
// each digit with its restoring divider and pulls the next entry once it is idle. An index
// passes the fold state when out of range, the push state, the queue, the divider steps
// and the output registers. A two-entry queue lets the front end take further indices
// while the engine is busy.
// Reset: synchronous, active low; restores radix 2 and 16 digits and rebuilds the table
// (busy high meanwhile). The receiver cannot stall: every strobe is a delivered beat.
module radix_digit_decomposer #(
  parameter int MAX_DIGITS  = rdd_pkg::MAX_DIGITS_DEF,
  parameter int INDEX_WIDTH = rdd_pkg::INDEX_WIDTH_DEF,
  parameter int DIGIT_WIDTH = rdd_pkg::DIGIT_WIDTH_DEF,
  localparam int PW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [INDEX_WIDTH-1:0]              in_index_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rdd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [rdd_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
  output logic                                out_strobe,
  output logic [DIGIT_WIDTH-1:0]              out_digit,
  output logic [PW-1:0]                       out_position,
  output logic                                out_last,
  output logic                                out_out_of_range
);
  import rdd_pkg::*;

  localparam int RW = DIGIT_WIDTH + 1;
  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic [RW-1:0]          eff_radix;
  logic [CW-1:0]          eff_count;
  logic [INDEX_WIDTH-1:0] total;
  logic                   total_sat;
  logic [PW-1:0]          pv_addr;
  logic [INDEX_WIDTH-1:0] pv_data;
  logic                   front_busy;
  logic                   accept;
  logic                   q_push;
  logic [INDEX_WIDTH:0]   q_wdata;
  logic                   q_full;
  logic                   q_pop;
  logic [INDEX_WIDTH:0]   q_rdata;
  logic                   q_empty;

  assign busy   = front_busy || !cfg_ready;
  assign accept = start && !busy;

  rdd_place_table #(
    .MAX_DIGITS (MAX_DIGITS),
    .INDEX_WIDTH(INDEX_WIDTH),
    .DIGIT_WIDTH(DIGIT_WIDTH)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .eff_radix(eff_radix),
    .eff_count(eff_count),
    .total    (total),
    .total_sat(total_sat),
    .rd_addr  (pv_addr),
    .rd_data  (pv_data)
  );

  rdd_front #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .index_i    (in_index_value),
    .total_i    (total),
    .total_sat_i(total_sat),
    .busy_o     (front_busy),
    .q_push     (q_push),
    .q_data     (q_wdata),
    .q_full     (q_full)
  );

  rdd_queue #(
    .WIDTH(INDEX_WIDTH + 1),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .empty    (q_empty)
  );

  rdd_back #(
    .MAX_DIGITS (MAX_DIGITS),
    .INDEX_WIDTH(INDEX_WIDTH),
    .DIGIT_WIDTH(DIGIT_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .eff_count   (eff_count),
    .pv_addr     (pv_addr),
    .pv_data     (pv_data),
    .out_strobe  (out_strobe),
    .out_digit   (out_digit),
    .out_position(out_position),
    .out_last    (out_last),
    .out_oor     (out_out_of_range)
  );

`ifndef SYNTHESIS
  a_digit_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ({1'b0, out_digit} < eff_radix))
    else $error("digit not below radix");

  a_last_at_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |-> (out_position == PW'(eff_count - CW'(1))))
    else $error("last beat at wrong position");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("front end did not hold after accepting an index");
`endif

endmodule

[verif/tb_radix_digit_decomposer.sv]
// Self-checking testbench for radix_digit_decomposer: directed table, then randomised phases.
module tb_radix_digit_decomposer;
  timeunit 1ns;
  timeprecision 1ps;

  import rdd_pkg::*;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED = CFG_INDEX_WIDTH'(7);
  localparam longint unsigned INDEX_MASK = 64'hFFFF_FFFF;
  localparam longint unsigned RADIX_CEIL = longint'(1) << DIGIT_WIDTH_DEF;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 20;

  typedef struct packed {
    logic [7:0] digit;
    logic [3:0] position;
    logic       last;
    logic       out_of_range;
  } digit_beat_t;

  typedef enum logic {ROW_CFG, ROW_IDX} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic [CFG_INDEX_WIDTH-1:0] reg_idx;
    logic [31:0]                value;
    bit                         typed;
    logic [7:0]                 t_digit;
    int                         t_count;
    bit                         t_oor;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [31:0]                in_index_value;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata;
  logic                       out_strobe;
  logic [7:0]                 out_digit;
  logic [3:0]                 out_position;
  logic                       out_last;
  logic                       out_out_of_range;

  digit_beat_t     pending_digits[$];
  digit_beat_t     want_beat;
  int              fail_count = 0;

  logic [8:0]      cur_radix;
  logic [4:0]      cur_count;
  longint unsigned base_used;
  longint unsigned count_used;
  longint unsigned place_weight[16];
  longint unsigned span_total;
  bit              span_saturated;

  stim_row_t directed_rows[24] = '{
    '{ROW_IDX, REG_RADIX,       32'h0000_0000, 1'b1, 8'd0,   16, 1'b0},
    '{ROW_IDX, REG_RADIX,       32'h0000_FFFF, 1'b1, 8'd1,   16, 1'b0},
    '{ROW_IDX, REG_RADIX,       32'h0001_0000, 1'b1, 8'd0,   16, 1'b1},
    '{ROW_IDX, REG_RADIX,       32'hFFFF_FFFF, 1'b1, 8'd1,   16, 1'b1},
    '{ROW_IDX, REG_RADIX,       32'h0001_2345, 1'b0, 8'd0,   0,  1'b0},
    '{ROW_CFG, REG_RADIX,       32'd10,        1'b0, 8'd0,   0,  1'b0},
    '{ROW_CFG, REG_DIGIT_COUNT, 32'd3,         1'b0, 8'd0,   0,  1'b0},
    '{ROW_IDX, REG_RADIX,       32'd999,       1'b1, 8'd9,   3,  1'b0},
    '{ROW_IDX, REG_RADIX,       32'd1000,      1'b1, 8'd0,   3,  1'b1},
    '{ROW_IDX, REG_RADIX,       32'd123,       1'b0, 8'd0,   0,  1'b0},
    '{ROW_CFG, REG_RADIX,       32'h0000_01FF, 1'b0, 8'd0,   0,  1'b0},
    '{ROW_CFG, REG_DIGIT_COUNT, 32'd4,         1'b0, 8'd0,   0,  1'b0},
    '{ROW_IDX, REG_RADIX,       32'hFFFF_FFFF, 1'b1, 8'd255, 4,  1'b0},
    '{ROW_IDX, REG_RADIX,       32'h0102_0304, 1'b0, 8'd0,   0,  1'b0},
    '{ROW_CFG, REG_DIGIT_COUNT, 32'd0,         1'b0, 8'd0,   0,  1'b0},
    '{ROW_IDX, REG_RADIX,       32'hFFFF_FFFF, 1'b1, 8'd255, 1,  1'b1},
    '{ROW_CFG, REG_RADIX,       32'd1,         1'b0, 8'd0,   0,  1'b0},
    '{ROW_CFG, REG_DIGIT_COUNT, 32'd31,        1'b0, 8'd0,   0,  1'b0},
    '{ROW_IDX, REG_RADIX,       32'hAAAA_AAAA, 1'b0, 8'd0,   0,  1'b0},
    '{ROW_CFG, REG_UNMAPPED,    32'h0000_FFFF, 1'b0, 8'd0,   0,  1'b0},
    '{ROW_CFG, REG_RADIX,       32'd0,         1'b0, 8'd0,   0,  1'b0},
    '{ROW_IDX, REG_RADIX,       32'h0000_5555, 1'b0, 8'd0,   0,  1'b0},
    '{ROW_CFG, REG_RADIX,       32'd7,         1'b0, 8'd0,   0,  1'b0},
    '{ROW_IDX, REG_RADIX,       32'hFFFF_FFFF, 1'b0, 8'd0,   0,  1'b0}
  };

  radix_digit_decomposer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_index_value   (in_index_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_strobe       (out_strobe),
    .out_digit        (out_digit),
    .out_position     (out_position),
    .out_last         (out_last),
    .out_out_of_range (out_out_of_range)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void rebuild_places();
    longint unsigned pv;
    bit sat;
    base_used  = (cur_radix < 2) ? 2 : (cur_radix > RADIX_CEIL) ? RADIX_CEIL : cur_radix;
    count_used = (cur_count < 1) ? 1 : (cur_count > MAX_DIGITS_DEF) ? MAX_DIGITS_DEF : cur_count;
    pv  = 1;
    sat = 1'b0;
    for (int k = 0; k < 16; k++) place_weight[k] = 0;
    for (int k = int'(count_used) - 1; k >= 0; k--) begin
      place_weight[k] = pv;
      if (sat || pv > INDEX_MASK / base_used) begin
        sat = 1'b1;
        pv  = INDEX_MASK;
      end else begin
        pv = pv * base_used;
      end
    end
    span_total     = pv;
    span_saturated = sat;
  endfunction

  function automatic void predict_digits(input logic [31:0] idx);
    longint unsigned x;
    longint unsigned d;
    bit oor;
    x   = idx;
    oor = !span_saturated && x >= span_total;
    for (int k = 0; k < int'(count_used); k++) begin
      if (place_weight[k] == INDEX_MASK && k + 1 < int'(count_used)) d = 0;
      else d = (x / place_weight[k]) % base_used;
      pending_digits.push_back('{d[7:0], k[3:0], (k + 1 == int'(count_used)), oor});
    end
  endfunction

  function automatic logic [31:0] pick_index();
    logic [31:0] x;
    x = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        if (!span_saturated) x = 32'(longint'($urandom) % span_total);
      end
      4, 5: begin
        if (!span_saturated) x = 32'(span_total - longint'($urandom_range(1)));
        else x = 32'hFFFF_FFFF - 32'($urandom_range(3));
      end
      default: ;
    endcase
    return x;
  endfunction

  task automatic drain_digits();
    @(posedge clk);
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    start <= 1'b0;
    drain_digits();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_RADIX) begin
      cur_radix = data[8:0];
      rebuild_places();
    end else if (idx == REG_DIGIT_COUNT) begin
      cur_count = data[4:0];
      rebuild_places();
    end
  endtask

  task automatic send_index(input logic [31:0] idx, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_index_value <= idx;
    do @(posedge clk); while (busy);
  endtask

  task automatic report_field(input string name, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected digit beat, expected none, actual digit %0d position %0d",
                 $time, out_digit, out_position);
        fail_count++;
      end else begin
        want_beat = pending_digits.pop_front();
        if (out_digit !== want_beat.digit)
          report_field("digit", want_beat.digit, out_digit);
        if (out_position !== want_beat.position)
          report_field("position", want_beat.position, out_position);
        if (out_last !== want_beat.last)
          report_field("last", want_beat.last, out_last);
        if (out_out_of_range !== want_beat.out_of_range)
          report_field("out_of_range", want_beat.out_of_range, out_out_of_range);
      end
    end
  end

  initial begin
    int idle_pct;
    logic [8:0] rdx;
    logic [4:0] cnt;
    logic [31:0] next_index;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_index_value = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    cur_radix      = RADIX_RESET;
    cur_count      = COUNT_RESET;
    rebuild_places();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value[CFG_DATA_WIDTH-1:0]);
      end else begin
        send_index(directed_rows[i].value, 0);
        if (directed_rows[i].typed) begin
          for (int k = 0; k < directed_rows[i].t_count; k++)
            pending_digits.push_back('{directed_rows[i].t_digit, k[3:0],
                                       (k + 1 == directed_rows[i].t_count),
                                       directed_rows[i].t_oor});
        end else begin
          predict_digits(directed_rows[i].value);
        end
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 76;
        default: idle_pct = 7;
      endcase
      case ($urandom_range(5))
        0:       rdx = 9'd2;
        1:       rdx = 9'd256;
        2:       rdx = 9'd10;
        3:       rdx = 9'($urandom_range(511));
        default: rdx = 9'($urandom_range(255, 3));
      endcase
      case ($urandom_range(7))
        0:       cnt = 5'd16;
        1:       cnt = 5'd1;
        2:       cnt = 5'($urandom_range(31));
        default: cnt = 5'($urandom_range(6, 1));
      endcase
      write_reg(REG_RADIX, {7'($urandom_range(127)), rdx});
      write_reg(REG_DIGIT_COUNT, {11'($urandom_range(2047)), cnt});
      write_reg(CFG_INDEX_WIDTH'($urandom_range(15, 2)), 16'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == PHASE_ITEMS / 2) begin
          start <= 1'b0;
          drain_digits();
        end
        next_index = pick_index();
        send_index(next_index, idle_pct);
        predict_digits(next_index);
      end
    end

    start <= 1'b0;
    drain_digits();
    repeat (160) @(posedge clk);
    if (fail_count == 0) $display("tb_radix_digit_decomposer: PASS");
    else $display("tb_radix_digit_decomposer: FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_radix_digit_decomposer: FAIL");
    $finish;
  end

endmodule

[sim.f]
design/rdd_pkg.sv
design/rdd_place_table.sv
design/rdd_front.sv
design/rdd_queue.sv
design/rdd_back.sv
design/radix_digit_decomposer.sv
verif/tb_radix_digit_decomposer.sv
